>>> rtl/mclb_pkg.sv
// Shared types and constants of the multi-channel LED blinker.
package mclb_pkg;

  typedef enum logic [2:0] {
    KIND_INIT   = 3'd0,
    KIND_SET    = 3'd1,
    KIND_TOGGLE = 3'd2,
    KIND_BLINK  = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_TICK   = 3'd5
  } kind_e;

  // At most this many results come out of one tick.
  localparam int unsigned MaxResults = 8;
  localparam int unsigned ResCntW    = 4;

  // Command travelling along the row of channel cells.
  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic [5:0]         pin;
    logic               level;
    logic [14:0]        times;
    logic [15:0]        delay;
    logic [31:0]        now;
    logic               found;
    logic               on;
    logic [ResCntW-1:0] n;
  } tok_t;

  // One step result raised by a cell during a tick.
  typedef struct packed {
    logic       valid;
    logic [5:0] pin;
    logic       on;
  } emit_t;

endpackage

>>> rtl/mclb_if.sv
// Valid/ready channel interfaces for command and result beats.
interface mclb_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  pin;
  logic        level;
  logic [14:0] times;
  logic [15:0] delay_ms;
  logic [31:0] now;

  modport source (output valid, kind, pin, level, times, delay_ms, now, input ready);
  modport sink   (input valid, kind, pin, level, times, delay_ms, now, output ready);
endinterface

interface mclb_res_if;
  logic       valid;
  logic       ready;
  logic       drive_valid;
  logic [5:0] pin_out;
  logic       pin_level;
  logic       led_on;
  logic       found;
  logic       last;

  modport source (output valid, drive_valid, pin_out, pin_level, led_on, found, last,
                  input ready);
  modport sink   (input valid, drive_valid, pin_out, pin_level, led_on, found, last,
                  output ready);
endinterface

>>> rtl/multi_channel_led_blinker.sv
// Top level of the multi-channel LED blinker: the row of channel cells and the result stage.
//
// A command beat enters a row of CHANNELS cells, each holding one LED channel, and moves
// one cell per cycle whenever the output register can take a beat; a pin is found in the
// cell that holds it or added in the first free cell. A new command is taken only after the
// last one has walked the whole row and reached the result stage, and a stalled result side
// holds it back further. A tick gives one result for each due blinking channel in table
// order, at most eight, the last one marked; a tick with nothing due gives none. Every other
// command gives exactly one result. Pins are active low, so a lit LED is driven with level 0.
module multi_channel_led_blinker #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mclb_cmd_if.sink   cmd_i,
  mclb_res_if.source res_o
);

  mclb_pkg::tok_t  tok_link [CHANNELS+1];
  mclb_pkg::emit_t emits    [CHANNELS];
  mclb_pkg::emit_t emit_any;
  mclb_pkg::tok_t  fin_q;

  logic       adv;
  logic       accept;
  logic       busy_q;
  logic       held_vq, held_vd;
  logic [5:0] held_pin_q, held_pin_d;
  logic       held_on_q, held_on_d;

  logic       out_vq;
  logic       out_load;
  logic       ld_drive, ld_level, ld_on, ld_found, ld_last;
  logic [5:0] ld_pin;
  logic       o_drive_q, o_level_q, o_on_q, o_found_q, o_last_q;
  logic [5:0] o_pin_q;

  // The whole row moves only when the output register can take a beat.
  assign adv         = !out_vq || res_o.ready;
  assign cmd_i.ready = !busy_q && adv;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    tok_link[0]       = '0;
    tok_link[0].valid = accept;
    tok_link[0].kind  = cmd_i.kind;
    tok_link[0].pin   = cmd_i.pin;
    tok_link[0].level = cmd_i.level;
    tok_link[0].times = cmd_i.times;
    tok_link[0].delay = cmd_i.delay_ms;
    tok_link[0].now   = cmd_i.now;
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    mclb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tok_i  (tok_link[g]),
      .tok_o  (tok_link[g+1]),
      .emit_o (emits[g])
    );
  end

  // Only the cell holding the command can raise a result, so an OR collects it.
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      emit_any = emit_any | emits[i];
    end
  end

  // A tick result is held back one step so that the final one can carry the last flag.
  always_comb begin
    out_load   = 1'b0;
    ld_drive   = 1'b0;
    ld_pin     = fin_q.pin;
    ld_level   = 1'b1;
    ld_on      = 1'b0;
    ld_found   = 1'b0;
    ld_last    = 1'b1;
    held_vd    = held_vq;
    held_pin_d = held_pin_q;
    held_on_d  = held_on_q;
    if (adv) begin
      if (emit_any.valid) begin
        if (held_vq) begin
          out_load = 1'b1;
          ld_drive = 1'b1;
          ld_pin   = held_pin_q;
          ld_level = !held_on_q;
          ld_on    = held_on_q;
          ld_found = 1'b1;
          ld_last  = 1'b0;
        end
        held_vd    = 1'b1;
        held_pin_d = emit_any.pin;
        held_on_d  = emit_any.on;
      end else if (fin_q.valid) begin
        unique case (fin_q.kind)
          mclb_pkg::KIND_TICK: begin
            out_load = held_vq;
            ld_drive = 1'b1;
            ld_pin   = held_pin_q;
            ld_level = !held_on_q;
            ld_on    = held_on_q;
            ld_found = 1'b1;
            held_vd  = 1'b0;
          end
          mclb_pkg::KIND_INIT: begin
            out_load = 1'b1;
            ld_drive = 1'b1;
            ld_found = fin_q.found;
          end
          mclb_pkg::KIND_SET: begin
            out_load = 1'b1;
            ld_drive = 1'b1;
            ld_level = !fin_q.level;
            ld_on    = fin_q.found && fin_q.level;
            ld_found = fin_q.found;
          end
          mclb_pkg::KIND_TOGGLE, mclb_pkg::KIND_BLINK: begin
            out_load = 1'b1;
            ld_drive = fin_q.found;
            ld_level = !(fin_q.found && fin_q.on);
            ld_on    = fin_q.found && fin_q.on;
            ld_found = fin_q.found;
          end
          mclb_pkg::KIND_QUERY: begin
            out_load = 1'b1;
            ld_on    = fin_q.found && fin_q.on;
            ld_found = fin_q.found;
          end
          default: begin
            out_load = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= '0;
      held_vq <= 1'b0;
      out_vq  <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (adv && fin_q.valid) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        fin_q <= tok_link[CHANNELS];
      end
      held_vq <= held_vd;
      if (out_load) begin
        out_vq <= 1'b1;
      end else if (res_o.ready) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held_pin_q <= held_pin_d;
    held_on_q  <= held_on_d;
    if (out_load) begin
      o_drive_q <= ld_drive;
      o_pin_q   <= ld_pin;
      o_level_q <= ld_level;
      o_on_q    <= ld_on;
      o_found_q <= ld_found;
      o_last_q  <= ld_last;
    end
  end

  assign res_o.valid       = out_vq;
  assign res_o.drive_valid = o_drive_q;
  assign res_o.pin_out     = o_pin_q;
  assign res_o.pin_level   = o_level_q;
  assign res_o.led_on      = o_on_q;
  assign res_o.found       = o_found_q;
  assign res_o.last        = o_last_q;

endmodule

>>> rtl/mclb_cell.sv
// One channel entry of the table, acting on the command as it passes by.
module mclb_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  mclb_pkg::tok_t  tok_i,
  output mclb_pkg::tok_t  tok_o,
  output mclb_pkg::emit_t emit_o
);

  mclb_pkg::tok_t tok_q;
  logic        used_q, used_d;
  logic [5:0]  pin_q, pin_d;
  logic        on_q, on_d;
  logic        blink_q, blink_d;
  logic [31:0] last_q, last_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] total_q, total_d;
  logic [15:0] delay_q, delay_d;

  logic        is_lookup;
  logic        hit;
  logic        create;
  logic        base_on;
  logic [31:0] elapsed;
  logic [15:0] cnt_inc;
  logic        due;

  assign is_lookup = (tok_q.kind == mclb_pkg::KIND_INIT) ||
                     (tok_q.kind == mclb_pkg::KIND_SET) ||
                     (tok_q.kind == mclb_pkg::KIND_TOGGLE) ||
                     (tok_q.kind == mclb_pkg::KIND_BLINK) ||
                     (tok_q.kind == mclb_pkg::KIND_QUERY);
  // Entries fill from the front, so the first free cell is the place to add a pin.
  assign hit     = used_q && (pin_q == tok_q.pin);
  assign create  = !used_q;
  assign base_on = create ? 1'b0 : on_q;
  assign elapsed = tok_q.now - last_q;
  assign cnt_inc = cnt_q + 16'd1;
  assign due     = (tok_q.kind == mclb_pkg::KIND_TICK) && used_q && blink_q &&
                   (tok_q.n < mclb_pkg::ResCntW'(mclb_pkg::MaxResults)) &&
                   (elapsed >= {16'd0, delay_q});

  always_comb begin
    tok_o   = tok_q;
    emit_o  = '0;
    used_d  = used_q;
    pin_d   = pin_q;
    on_d    = on_q;
    blink_d = blink_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    delay_d = delay_q;
    if (tok_q.valid) begin
      if (is_lookup && !tok_q.found && (hit || create)) begin
        if (create) begin
          used_d  = 1'b1;
          pin_d   = tok_q.pin;
          on_d    = 1'b0;
          blink_d = 1'b0;
          last_d  = '0;
          cnt_d   = '0;
          total_d = '0;
          delay_d = '0;
        end
        tok_o.found = 1'b1;
        unique case (tok_q.kind)
          mclb_pkg::KIND_INIT: begin
            on_d     = 1'b0;
            tok_o.on = 1'b0;
          end
          mclb_pkg::KIND_SET: begin
            on_d     = tok_q.level;
            blink_d  = 1'b0;
            tok_o.on = tok_q.level;
          end
          mclb_pkg::KIND_TOGGLE: begin
            on_d     = !base_on;
            blink_d  = 1'b0;
            tok_o.on = !base_on;
          end
          mclb_pkg::KIND_BLINK: begin
            blink_d  = 1'b1;
            cnt_d    = '0;
            total_d  = {tok_q.times, 1'b0};
            delay_d  = tok_q.delay;
            last_d   = tok_q.now;
            on_d     = 1'b1;
            tok_o.on = 1'b1;
          end
          mclb_pkg::KIND_QUERY: begin
            tok_o.on = base_on;
          end
          default: begin
          end
        endcase
      end else if (due) begin
        cnt_d = cnt_inc;
        if (cnt_inc >= total_q) begin
          blink_d = 1'b0;
          on_d    = 1'b0;
        end else begin
          on_d   = !on_q;
          last_d = tok_q.now;
        end
        emit_o.valid = 1'b1;
        emit_o.pin   = pin_q;
        emit_o.on    = on_d;
        tok_o.n      = tok_q.n + mclb_pkg::ResCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      used_q <= 1'b0;
    end else if (adv_i) begin
      tok_q  <= tok_i;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pin_q       <= pin_d;
      on_q        <= on_d;
      blink_q     <= blink_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      delay_q     <= delay_d;
    end
  end

endmodule

>>> test/mclb_checker.sv
// Checker that tracks the LED channel table and compares every result beat with its prediction.
module mclb_checker #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  mclb_cmd_if  cmd_i,
  mclb_res_if  res_i,
  output int   errors_o,
  output int   pending_o,
  output int   cmds_o,
  output int   beats_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  pin;
    logic        on;
    logic        blinking;
    logic [31:0] last_t;
    logic [15:0] steps;
    logic [15:0] total;
    logic [15:0] delay;
  } led_chan_t;

  typedef struct packed {
    logic       drive;
    logic [5:0] pin;
    logic       level;
    logic       on;
    logic       found;
    logic       last;
  } led_res_t;

  led_chan_t chans [CHANNELS];
  int        used_chans;
  led_res_t  led_results_q [$];

  task automatic report_mismatch(input string msg);
    errors_o++;
    if (errors_o <= 30) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                beats_o, name, got, want));
    end
  endtask

  // Finds the channel of a pin, or claims the next free entry; -1 when the table is full.
  function automatic int lookup_channel(input logic [5:0] pin);
    for (int i = 0; i < used_chans; i++) begin
      if (chans[i].pin == pin) return i;
    end
    if (used_chans < CHANNELS) begin
      chans[used_chans] = '0;
      chans[used_chans].pin = pin;
      used_chans++;
      return used_chans - 1;
    end
    return -1;
  endfunction

  task automatic push_result(input logic drive, input logic [5:0] pin, input logic level,
                             input logic on, input logic found, input logic last);
    led_results_q.push_back({drive, pin, level, on, found, last});
  endtask

  task automatic step_led_table(input logic [2:0] kind, input logic [5:0] pin,
                                input logic level, input logic [14:0] times,
                                input logic [15:0] delay, input logic [31:0] now);
    int c;
    int n;
    c = -1;
    n = 0;
    unique case (kind)
      mclb_pkg::KIND_INIT: begin
        // Init only records the LED off; a running blink carries on.
        c = lookup_channel(pin);
        if (c >= 0) chans[c].on = 1'b0;
        push_result(1'b1, pin, 1'b1, 1'b0, c >= 0, 1'b1);
      end
      mclb_pkg::KIND_SET: begin
        c = lookup_channel(pin);
        if (c >= 0) begin
          chans[c].on = level;
          chans[c].blinking = 1'b0;
        end
        push_result(1'b1, pin, ~level, (c >= 0) ? level : 1'b0, c >= 0, 1'b1);
      end
      mclb_pkg::KIND_TOGGLE: begin
        c = lookup_channel(pin);
        if (c < 0) begin
          push_result(1'b0, pin, 1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          chans[c].on = ~chans[c].on;
          chans[c].blinking = 1'b0;
          push_result(1'b1, pin, ~chans[c].on, chans[c].on, 1'b1, 1'b1);
        end
      end
      mclb_pkg::KIND_BLINK: begin
        c = lookup_channel(pin);
        if (c < 0) begin
          push_result(1'b0, pin, 1'b1, 1'b0, 1'b0, 1'b1);
        end else begin
          chans[c].blinking = 1'b1;
          chans[c].steps = '0;
          chans[c].total = {times, 1'b0};
          chans[c].delay = delay;
          chans[c].last_t = now;
          chans[c].on = 1'b1;
          push_result(1'b1, pin, 1'b0, 1'b1, 1'b1, 1'b1);
        end
      end
      mclb_pkg::KIND_QUERY: begin
        c = lookup_channel(pin);
        push_result(1'b0, pin, 1'b1, (c >= 0) ? chans[c].on : 1'b0, c >= 0, 1'b1);
      end
      mclb_pkg::KIND_TICK: begin
        for (int i = 0; i < used_chans && n < mclb_pkg::MaxResults; i++) begin
          if (chans[i].blinking && (now - chans[i].last_t) >= {16'd0, chans[i].delay}) begin
            chans[i].steps = chans[i].steps + 16'd1;
            if (chans[i].steps >= chans[i].total) begin
              chans[i].blinking = 1'b0;
              chans[i].on = 1'b0;
            end else begin
              chans[i].on = ~chans[i].on;
              chans[i].last_t = now;
            end
            push_result(1'b1, chans[i].pin, ~chans[i].on, chans[i].on, 1'b1, 1'b0);
            n++;
          end
        end
        // Only the final step of a tick carries the last flag.
        if (n > 0) led_results_q[led_results_q.size() - 1].last = 1'b1;
      end
      default: push_result(1'b0, pin, 1'b1, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_beat();
    led_res_t got;
    led_res_t want;
    got = {res_i.drive_valid, res_i.pin_out, res_i.pin_level, res_i.led_on, res_i.found,
           res_i.last};
    beats_o++;
    if (led_results_q.size() == 0) begin
      report_mismatch($sformatf("beat %0d for pin %0d arrived with nothing outstanding",
                                beats_o, got.pin));
      return;
    end
    want = led_results_q.pop_front();
    compare_field("drive_valid", got.drive, want.drive);
    compare_field("pin_out", got.pin, want.pin);
    compare_field("pin_level", got.level, want.level);
    compare_field("led_on", got.on, want.on);
    compare_field("found", got.found, want.found);
    compare_field("last", got.last, want.last);
  endtask

  // Results are checked before a new command is applied, so same-edge beats stay in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_chans = 0;
      foreach (chans[i]) chans[i] = '0;
      led_results_q.delete();
      errors_o = 0;
      cmds_o = 0;
      beats_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) check_beat();
      if (cmd_i.valid && cmd_i.ready) begin
        cmds_o++;
        step_led_table(cmd_i.kind, cmd_i.pin, cmd_i.level, cmd_i.times, cmd_i.delay_ms,
                       cmd_i.now);
      end
    end
    pending_o = led_results_q.size();
  end

endmodule

>>> test/multi_channel_led_blinker_test.sv
// Testbench top of the LED blinker: clock, reset, command stimulus, result back-pressure, verdict.
module multi_channel_led_blinker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Channels    = 8;
  localparam int unsigned Latency     = Channels + 2;
  localparam int unsigned DrainCycles = 4 * Latency;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 250000;
  localparam logic [2:0]  KindRsvdLo  = 3'd6;
  localparam logic [2:0]  KindRsvdHi  = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mclb_cmd_if cmd_bus ();
  mclb_res_if res_bus ();

  int          errors;
  int          pending;
  int          cmds_seen;
  int          beats_seen;
  int unsigned cycle_cnt;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req_cnt;
  logic [5:0]  led_pins [Channels];
  logic [31:0] clock_ms;
  mclb_pkg::kind_e lookup_kinds [5] = '{mclb_pkg::KIND_INIT, mclb_pkg::KIND_SET,
                                        mclb_pkg::KIND_TOGGLE, mclb_pkg::KIND_BLINK,
                                        mclb_pkg::KIND_QUERY};

  multi_channel_led_blinker #(
    .CHANNELS(Channels)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  mclb_checker #(
    .CHANNELS(Channels)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_bus),
    .res_i    (res_bus),
    .errors_o (errors),
    .pending_o(pending),
    .cmds_o   (cmds_seen),
    .beats_o  (beats_seen)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req_cnt) begin
        hold_seen = hold_req_cnt;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_cmd(input logic [2:0] kind, input logic [5:0] pin, input logic level,
                          input logic [14:0] times, input logic [15:0] delay,
                          input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.kind     <= kind;
    cmd_bus.pin      <= pin;
    cmd_bus.level    <= level;
    cmd_bus.times    <= times;
    cmd_bus.delay_ms <= delay;
    cmd_bus.now      <= now;
    do @(posedge clk_i); while (!cmd_bus.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [5:0] pick_missing_pin();
    logic [5:0] p;
    bit         clash;
    do begin
      p = 6'($urandom());
      clash = 1'b0;
      foreach (led_pins[i]) if (led_pins[i] == p) clash = 1'b1;
    end while (clash);
    return p;
  endfunction

  // The sender goes quiet and waits until no expected result is outstanding.
  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Mostly well-formed traffic on the known pins, with ticks moving time forward.
  task automatic send_random_cmd();
    int          roll;
    logic [2:0]  kind;
    logic [5:0]  pin;
    logic [14:0] times;
    logic [15:0] delay;
    roll  = $urandom_range(99);
    pin   = led_pins[$urandom_range(Channels - 1)];
    times = ($urandom_range(9) == 0) ? 15'($urandom_range(32767)) : 15'($urandom_range(4));
    delay = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(12));
    if (roll < 35) begin
      kind = mclb_pkg::KIND_TICK;
      clock_ms += ($urandom_range(19) == 0) ? $urandom() : $urandom_range(15);
    end else if (roll < 55) begin
      kind = mclb_pkg::KIND_BLINK;
    end else if (roll < 63) begin
      kind = mclb_pkg::KIND_SET;
    end else if (roll < 71) begin
      kind = mclb_pkg::KIND_TOGGLE;
    end else if (roll < 79) begin
      kind = mclb_pkg::KIND_INIT;
    end else if (roll < 87) begin
      kind = mclb_pkg::KIND_QUERY;
    end else if (roll < 89) begin
      kind = roll[0] ? KindRsvdHi : KindRsvdLo;
    end else begin
      // Lookups of pins that no longer fit in the full table.
      kind = lookup_kinds[$urandom_range(4)];
      pin  = pick_missing_pin();
    end
    send_cmd(kind, pin, 1'($urandom()), times, delay, clock_ms);
  endtask

  initial begin
    cmd_bus.valid    = 1'b0;
    cmd_bus.kind     = mclb_pkg::KIND_INIT;
    cmd_bus.pin      = '0;
    cmd_bus.level    = 1'b0;
    cmd_bus.times    = '0;
    cmd_bus.delay_ms = '0;
    cmd_bus.now      = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req_cnt     = 0;
    clock_ms         = $urandom();
    foreach (led_pins[i]) led_pins[i] = '0;
    led_pins[1] = 6'd63;
    for (int i = 2; i < Channels; i++) led_pins[i] = pick_missing_pin();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: lowest and highest pins first, then fill the table.
    send_cmd(mclb_pkg::KIND_QUERY, 6'd0, 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_INIT, 6'd63, 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_SET, 6'd0, 1'b1, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_TOGGLE, 6'd63, 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_TICK, 6'd0, 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_BLINK, 6'd0, 1'b0, 15'd0, 16'd0, clock_ms);
    send_cmd(mclb_pkg::KIND_INIT, 6'd0, 1'b0, '0, '0, clock_ms);
    // A blink at the top of the time range that falls due exactly after the clock wraps.
    send_cmd(mclb_pkg::KIND_BLINK, 6'd63, 1'b1, 15'h7fff, 16'hffff, 32'hffff_fff0);
    send_cmd(mclb_pkg::KIND_TICK, 6'd0, 1'b0, '0, '0, 32'h0000_ffef);
    send_cmd(mclb_pkg::KIND_SET, 6'd63, 1'b0, '0, '0, clock_ms);
    for (int i = 2; i < Channels; i++) begin
      send_cmd(mclb_pkg::KIND_BLINK, led_pins[i], 1'b0, 15'd1, 16'd0, clock_ms);
    end
    send_cmd(mclb_pkg::KIND_BLINK, 6'd0, 1'b0, 15'd1, 16'd0, clock_ms);
    send_cmd(mclb_pkg::KIND_BLINK, 6'd63, 1'b0, 15'd1, 16'd0, clock_ms);
    clock_ms += 1;
    send_cmd(mclb_pkg::KIND_TICK, 6'd0, 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_SET, pick_missing_pin(), 1'($urandom()), '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_INIT, pick_missing_pin(), 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_TOGGLE, pick_missing_pin(), 1'b0, '0, '0, clock_ms);
    send_cmd(mclb_pkg::KIND_BLINK, pick_missing_pin(), 1'b0, 15'd3, 16'd2, clock_ms);
    send_cmd(mclb_pkg::KIND_QUERY, pick_missing_pin(), 1'b0, '0, '0, clock_ms);
    send_cmd(KindRsvdLo, 6'd0, 1'b1, 15'h7fff, 16'hffff, clock_ms);
    send_cmd(KindRsvdHi, 6'd63, 1'b0, '0, '0, clock_ms);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 18;
          recv_stall_pct = 18;
        end
      endcase
      if (phase == 0) begin
        // Hold the result side off while commands keep coming, so the input backs up.
        hold_req_cnt++;
        repeat (12) begin
          send_cmd(lookup_kinds[$urandom_range(4)], led_pins[$urandom_range(Channels - 1)],
                   1'($urandom()), 15'($urandom_range(3)), 16'($urandom_range(8)), clock_ms);
        end
      end
      repeat (18) send_random_cmd();
      wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d commands and checked %0d result beats in %0d cycles,", cmds_seen,
             beats_seen, cycle_cnt);
    $display("covering a full table, clock wrap, long blinks, stalls and a blocked input.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
